### hw/rtl/crc8fb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fb_pkg
// Shared constants, frame byte positions and the CRC-8 byte update function
// for the command frame builder.
// ----------------------------------------------------------------------------
package crc8fb_pkg;

	localparam int unsigned OPCODE_W  = 8;
	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned IN_DATA_W = OPCODE_W + PAYLOAD_W;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned POS_W     = $clog2(FRAME_LEN);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [POS_W-1:0]  pos_t;

	localparam byte_t START_BYTE = 8'h55;
	localparam byte_t STOP_BYTE  = 8'hAA;
	localparam byte_t CRC_POLY   = 8'h31;
	localparam byte_t CRC_INIT   = 8'h00;

	// Byte positions within one frame, in transmit order
	localparam pos_t POS_START = 3'd0;
	localparam pos_t POS_OPCODE = 3'd1;
	localparam pos_t POS_PAY3  = 3'd2;
	localparam pos_t POS_PAY2  = 3'd3;
	localparam pos_t POS_PAY1  = 3'd4;
	localparam pos_t POS_PAY0  = 3'd5;
	localparam pos_t POS_CRC   = 3'd6;
	localparam pos_t POS_STOP  = 3'd7;

	// Status from the serializer back to the input stage
	typedef struct packed {
		logic can_load;
	} ser_status_t;

	// One byte through CRC-8, MSB first, no reflection
	function automatic byte_t crc8_update(input byte_t crc_in, input byte_t data);
		byte_t c;
		c = crc_in ^ data;
		for (int b = 0; b < BYTE_W; b++) begin
			if (c[BYTE_W-1]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

### hw/rtl/crc8fb_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fb_serializer
// Holds one command and sends its 8-byte frame one byte per item, folding
// each sent command byte into the running CRC so the CRC byte is ready in turn.
// ----------------------------------------------------------------------------
module crc8fb_serializer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [crc8fb_pkg::OPCODE_W-1:0]  load_opcode,
	input  logic [crc8fb_pkg::PAYLOAD_W-1:0] load_payload,
	output crc8fb_pkg::ser_status_t     status,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [7:0] frame_byte
	output logic                        m_tlast
);
	import crc8fb_pkg::*;

	logic                 busy_q;
	pos_t                 pos_q;
	byte_t                opcode_q;
	logic [PAYLOAD_W-1:0] payload_q;
	byte_t                crc_q;
	byte_t                cur_byte;
	logic                 beat;
	logic                 last_beat;

	assign beat      = busy_q && m_tready;
	assign last_beat = beat && (pos_q == POS_STOP);

	assign status.can_load = !busy_q || last_beat;

	// Select the byte at the current frame position
	always_comb begin
		case (pos_q)
			POS_START:  cur_byte = START_BYTE;
			POS_OPCODE: cur_byte = opcode_q;
			POS_PAY3:   cur_byte = payload_q[31:24];
			POS_PAY2:   cur_byte = payload_q[23:16];
			POS_PAY1:   cur_byte = payload_q[15:8];
			POS_PAY0:   cur_byte = payload_q[7:0];
			POS_CRC:    cur_byte = crc_q;
			POS_STOP:   cur_byte = STOP_BYTE;
			default:    cur_byte = STOP_BYTE;
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = cur_byte;
	assign m_tlast  = (pos_q == POS_STOP);

	// Frame control: load a command, advance on each sent item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= POS_START;
		end else if (load && status.can_load) begin
			busy_q <= 1'b1;
			pos_q  <= POS_START;
		end else if (last_beat) begin
			busy_q <= 1'b0;
			pos_q  <= POS_START;
		end else if (beat) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// Command bytes and running CRC
	always_ff @(posedge clk) begin
		if (load && status.can_load) begin
			opcode_q  <= load_opcode;
			payload_q <= load_payload;
			crc_q     <= CRC_INIT;
		end else if (beat && (pos_q inside {[POS_OPCODE:POS_PAY0]})) begin
			crc_q <= crc8_update(crc_q, cur_byte);
		end
	end

endmodule

### hw/rtl/crc8_command_frame_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_command_frame_builder_core
// Frames one command (opcode, 32-bit payload) as 0x55, opcode, payload MSB
// first, CRC-8 (poly 0x31, init 0), 0xAA, sent one byte per output item.
// ----------------------------------------------------------------------------
// The first frame byte is offered once the command has passed the input
//   register and been loaded into the serializer.
// Throughput: one byte per cycle while m_tready is high, the CRC advancing one
//   byte per sent item in the serializer; next command loads at the stop byte.
// An input register takes the next command while the current frame is sent.
// Reset (arst_n low, asynchronous) empties both stages; no item is pending.
// ----------------------------------------------------------------------------
module crc8_command_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] opcode, [39:8] payload
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] frame_byte
	output logic        m_tlast
);
	import crc8fb_pkg::*;

	logic                 valid_s1;
	byte_t                opcode_s1;
	logic [PAYLOAD_W-1:0] payload_s1;
	ser_status_t          ser_status;
	logic                 hand_off;

	assign hand_off = valid_s1 && ser_status.can_load;
	assign s_tready = !valid_s1 || ser_status.can_load;

	// Input register: hold a command until the serializer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (hand_off) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1  <= s_tdata[OPCODE_W-1:0];
			payload_s1 <= s_tdata[IN_DATA_W-1:OPCODE_W];
		end
	end

	crc8fb_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1),
		.load_opcode  (opcode_s1),
		.load_payload (payload_s1),
		.status       (ser_status),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the CRC-8 command frame builder. Each command sent in is predicted as
// an 8-byte frame (start, opcode, payload MSB first, CRC-8, stop). Every frame
// byte that leaves the block is compared with the oldest predicted byte. Both
// stream sides idle at random, and the final stretch runs at full rate.
// ----------------------------------------------------------------------------
module testbench;

	import crc8fb_pkg::*;

	localparam time CLK_PERIOD = 12ns;
	localparam int  STALL_LIMIT = 2000;
	localparam int  TAIL_CYCLES = 16;

	typedef struct {
		byte_t value;
		logic  last;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;    // [7:0] opcode, [39:8] payload
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] frame_byte
	logic        m_tlast;

	frame_byte_t pending_bytes[$];
	int          error_count = 0;
	bit          bursts_on = 1'b0;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	crc8_command_frame_builder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// CRC-8 over opcode then payload, one bit at a time, MSB first
	function automatic byte_t crc8_of_command(input logic [OPCODE_W-1:0] opcode,
			input logic [PAYLOAD_W-1:0] payload);
		logic [OPCODE_W+PAYLOAD_W-1:0] bits;
		byte_t                         crc;
		logic                          feedback;
		bits = {opcode, payload};
		crc = CRC_INIT;
		for (int i = OPCODE_W + PAYLOAD_W - 1; i >= 0; i--) begin
			feedback = crc[7] ^ bits[i];
			crc = {crc[6:0], 1'b0};
			if (feedback) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	// Queue the eight bytes the frame for one command must carry
	function automatic void predict_frame(input logic [OPCODE_W-1:0] opcode,
			input logic [PAYLOAD_W-1:0] payload);
		byte_t       frame[FRAME_LEN];
		frame_byte_t fb;
		frame[0] = START_BYTE;
		frame[1] = opcode;
		frame[2] = payload[31:24];
		frame[3] = payload[23:16];
		frame[4] = payload[15:8];
		frame[5] = payload[7:0];
		frame[6] = crc8_of_command(opcode, payload);
		frame[7] = STOP_BYTE;
		for (int k = 0; k < FRAME_LEN; k++) begin
			fb.value = frame[k];
			fb.last = (k == FRAME_LEN - 1);
			pending_bytes.push_back(fb);
		end
	endfunction

	// Offer one command item; return in the step where it is accepted
	task automatic send_command(input logic [OPCODE_W-1:0] opcode,
			input logic [PAYLOAD_W-1:0] payload);
		int gap;
		gap = 0;
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {payload, opcode};
		do @(posedge clk); while (!s_tready);
		predict_frame(opcode, payload);
	endtask

	task automatic wait_frames_out();
		while (pending_bytes.size() != 0) @(posedge clk);
	endtask

	function automatic logic [PAYLOAD_W-1:0] pick_payload();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_opcode();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return OPCODE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Field extremes, the start and stop byte values as fields, and bit patterns
	task automatic test_directed_frames();
		logic [OPCODE_W-1:0]  ops[12];
		logic [PAYLOAD_W-1:0] pays[12];
		ops  = '{8'h00, 8'hFF, 8'h03, 8'h05, 8'h06, 8'h80,
			8'h01, 8'hAA, 8'h55, 8'h31, 8'h7F, 8'hFE};
		pays = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_03E8, 32'h0000_0000,
			32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h3131_3131, 32'h7FFF_FFFF, 32'hFEDC_BA98};
		for (int i = 0; i < 12; i++) begin
			send_command(ops[i], pays[i]);
		end
	endtask

	task automatic test_random_commands(input int count);
		for (int i = 0; i < count; i++) begin
			send_command(pick_opcode(), pick_payload());
		end
	endtask

	// Send two commands, hold the sender until every queued frame byte has left the block, then send six more
	task automatic test_drain_pause();
		send_command(pick_opcode(), pick_payload());
		send_command(pick_opcode(), pick_payload());
		s_tvalid <= 1'b0;
		wait_frames_out();
		test_random_commands(6);
	endtask

	// Full rate on both sides
	task automatic test_back_to_back();
		bursts_on = 1'b0;
		test_random_commands(30);
	endtask

	// Receiver: stall in random bursts while bursts are enabled
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (bursts_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 9) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	// Compare each accepted frame byte with the oldest prediction
	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected item: frame_byte=%02h last=%0b", m_tdata, m_tlast);
				error_count++;
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.value) begin
					$error("frame_byte: expected %02h, got %02h", want.value, m_tdata);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		bursts_on = 1'b1;
		test_directed_frames();
		test_random_commands(130);
		test_drain_pause();
		test_back_to_back();
		s_tvalid <= 1'b0;
		wait_frames_out();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/crc8fb_pkg.sv
hw/rtl/crc8fb_serializer.sv
hw/rtl/crc8_command_frame_builder_core.sv
tb/sv/testbench.sv
